[hw/rtl/ncd_pkg.sv]
// ---------------------------------------------------------------------------
// Negative cycle detector package
// Shared sizes, item types, state encoding and controller/datapath bundles.
// ---------------------------------------------------------------------------
package ncd_pkg;

    localparam int MAX_NODES = 4096;
    localparam int MAX_EDGES = 16384;
    localparam int DIST_BITS = 48;

    localparam int NODE_W   = $clog2(MAX_NODES);
    localparam int NCNT_W   = NODE_W + 1;
    localparam int EIDX_W   = $clog2(MAX_EDGES + 1);
    localparam int EADDR_W  = $clog2(MAX_EDGES);
    localparam int WEIGHT_W = 32;

    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    localparam logic IDX_NODE_COUNT  = 1'b0;
    localparam logic IDX_SOURCE_NODE = 1'b1;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [11:0]                edge_from;
        logic [11:0]                edge_to;
        logic signed [WEIGHT_W-1:0] edge_weight;
    } in_item_t;

    typedef struct packed {
        logic no_negative_cycle;
        logic edges_dropped;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_ADD,
        ST_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_READ_U,
        ST_EDGE,
        ST_EDGE_WAIT,
        ST_RELAX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept_add;
        logic accept_clear;
        logic accept_check;
        logic wipe;
        logic add_write;
        logic init;
        logic pop;
        logic pop_wait;
        logic read_u;
        logic edge_read;
        logic edge_wait;
        logic relax;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic wipe_last;
        logic src_out;
        logic init_last;
        logic used_zero;
        logic edge_zero;
        logic target_out;
        logic abort;
        logic out_busy;
    } status_t;

endpackage

[hw/rtl/ncd_ctrl.sv]
// ---------------------------------------------------------------------------
// Negative cycle detector controller
// Sequences edge loads, graph clears and the queue-driven relaxation walk.
// ---------------------------------------------------------------------------
module ncd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        in_kind,
    output logic              in_stall,
    input  ncd_pkg::status_t  status,
    output ncd_pkg::cmd_t     cmd
);
    import ncd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WIPE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_WIPE:
            begin
                if (status.wipe_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_kind)
                        KIND_ADD:   state_next = ST_ADD;
                        KIND_CLEAR: state_next = ST_WIPE;
                        KIND_CHECK: state_next = status.src_out ? ST_DONE : ST_INIT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD:       state_next = ST_IDLE;
            ST_INIT:
            begin
                if (status.init_last)
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:       state_next = status.used_zero ? ST_DONE : ST_POP_WAIT;
            ST_POP_WAIT:  state_next = ST_READ_U;
            ST_READ_U:    state_next = ST_EDGE;
            ST_EDGE:      state_next = status.edge_zero ? ST_POP : ST_EDGE_WAIT;
            ST_EDGE_WAIT: state_next = status.target_out ? ST_EDGE : ST_RELAX;
            ST_RELAX:     state_next = status.abort ? ST_DONE : ST_EDGE;
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        in_stall     = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept_add   = in_valid && (in_kind == KIND_ADD);
                cmd.accept_clear = in_valid && (in_kind == KIND_CLEAR);
                cmd.accept_check = in_valid && (in_kind == KIND_CHECK);
            end
            ST_WIPE:      cmd.wipe      = 1'b1;
            ST_ADD:       cmd.add_write = 1'b1;
            ST_INIT:      cmd.init      = 1'b1;
            ST_POP:       cmd.pop       = !status.used_zero;
            ST_POP_WAIT:  cmd.pop_wait  = 1'b1;
            ST_READ_U:    cmd.read_u    = 1'b1;
            ST_EDGE:      cmd.edge_read = !status.edge_zero;
            ST_EDGE_WAIT: cmd.edge_wait = 1'b1;
            ST_RELAX:     cmd.relax     = 1'b1;
            ST_DONE:      cmd.finish    = !status.out_busy;
            default:      cmd           = '0;
        endcase
    end

endmodule

[hw/rtl/ncd_datapath.sv]
// ---------------------------------------------------------------------------
// Negative cycle detector datapath
// Graph, node and queue memories, saturating relaxation and result register.
// ---------------------------------------------------------------------------
module ncd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ncd_pkg::cmd_t        cmd,
    input  ncd_pkg::in_item_t    in_item,
    input  logic [12:0]          node_count,
    input  logic [11:0]          source_node,
    input  logic                 out_stall,
    output ncd_pkg::status_t     status,
    output logic                 out_valid,
    output ncd_pkg::out_item_t   out_item
);
    import ncd_pkg::*;

    typedef struct packed {
        logic signed [DIST_BITS-1:0] dist_val;
        logic                        queued;
        logic [NCNT_W-1:0]           count;
    } node_t;

    typedef struct packed {
        logic [EIDX_W-1:0]          next;
        logic [NODE_W-1:0]          target;
        logic signed [WEIGHT_W-1:0] cost;
    } edge_t;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS - 1){1'b1}}};
    localparam logic [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS - 1){1'b0}}};

    logic [EIDX_W-1:0] adj_mem  [MAX_NODES];
    edge_t             edge_mem [MAX_EDGES];
    node_t             node_mem [MAX_NODES];
    logic [NODE_W-1:0] wq_mem   [MAX_NODES];

    logic [EIDX_W-1:0] adj_rd;
    edge_t             edge_rd;
    node_t             node_rd;
    logic [NODE_W-1:0] wq_rd;

    logic [NCNT_W-1:0]    n_reg;
    logic [NODE_W-1:0]    src_reg;
    logic [NODE_W-1:0]    from_reg;
    logic [NODE_W-1:0]    to_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [EIDX_W-1:0]    edge_count_reg;
    logic                 overflow_reg;
    logic [NODE_W-1:0]    wipe_cnt_reg;
    logic [NODE_W-1:0]    init_cnt_reg;
    logic [NODE_W-1:0]    head_reg;
    logic [NODE_W-1:0]    tail_reg;
    logic [NCNT_W-1:0]    used_reg;
    logic [NODE_W-1:0]    u_reg;
    logic [DIST_BITS-1:0] du_reg;
    logic [EIDX_W-1:0]    e_reg;
    logic [NODE_W-1:0]    v_reg;
    logic [DIST_BITS-1:0] nd_reg;
    logic                 verdict_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    logic [NCNT_W-1:0]    n_live;
    logic                 edge_full;
    logic [DIST_BITS-1:0] w_ext;
    logic [DIST_BITS:0]   sum;
    logic [DIST_BITS-1:0] nd_sat;
    logic                 relax_hit;
    logic [NCNT_W-1:0]    new_count;
    logic                 push;

    logic                 adj_we;
    logic [NODE_W-1:0]    adj_waddr;
    logic [EIDX_W-1:0]    adj_wdata;
    logic [NODE_W-1:0]    adj_raddr;
    logic                 node_we;
    logic [NODE_W-1:0]    node_waddr;
    node_t                node_wdata;
    logic [NODE_W-1:0]    node_raddr;
    logic                 wq_we;
    logic [NODE_W-1:0]    wq_waddr;
    logic [NODE_W-1:0]    wq_wdata;
    logic                 edge_we;
    logic [EADDR_W-1:0]   edge_raddr;
    logic [EIDX_W-1:0]    e_minus;

    always_comb
    begin
        if (node_count == '0)
        begin
            n_live = NCNT_W'(1);
        end
        else if (node_count > NCNT_W'(MAX_NODES))
        begin
            n_live = NCNT_W'(MAX_NODES);
        end
        else
        begin
            n_live = node_count;
        end
    end

    assign edge_full = (edge_count_reg == EIDX_W'(MAX_EDGES));
    assign w_ext     = {{(DIST_BITS - WEIGHT_W){edge_rd.cost[WEIGHT_W-1]}}, edge_rd.cost};
    assign sum       = {du_reg[DIST_BITS-1], du_reg} + {w_ext[DIST_BITS-1], w_ext};

    always_comb
    begin
        if (sum[DIST_BITS] != sum[DIST_BITS-1])
        begin
            nd_sat = sum[DIST_BITS] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            nd_sat = sum[DIST_BITS-1:0];
        end
    end

    assign relax_hit = ($signed(node_rd.dist_val) > $signed(nd_reg));
    assign new_count = node_rd.count + NCNT_W'(1);
    assign push      = cmd.relax && relax_hit && !node_rd.queued && !status.abort;

    assign status.wipe_last  = (wipe_cnt_reg == NODE_W'(MAX_NODES - 1));
    assign status.src_out    = ({1'b0, source_node} >= n_live);
    assign status.init_last  = ({1'b0, init_cnt_reg} == (n_reg - NCNT_W'(1)));
    assign status.used_zero  = (used_reg == '0);
    assign status.edge_zero  = (e_reg == '0);
    assign status.target_out = ({1'b0, edge_rd.target} >= n_reg);
    assign status.abort      = relax_hit && !node_rd.queued && (new_count > n_reg);
    assign status.out_busy   = out_valid_reg && out_stall;

    // Adjacency heads: cleared by the wipe sweep, linked by edge loads.
    assign adj_we    = cmd.wipe || (cmd.add_write && !edge_full);
    assign adj_waddr = cmd.wipe ? wipe_cnt_reg : from_reg;
    assign adj_wdata = cmd.wipe ? '0 : (edge_count_reg + EIDX_W'(1));
    assign adj_raddr = cmd.accept_add ? in_item.edge_from : wq_rd;

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_rd <= adj_mem[adj_raddr];
    end

    // Edge records are stored at edge number minus one.
    assign edge_we    = cmd.add_write && !edge_full;
    assign e_minus    = e_reg - EIDX_W'(1);
    assign edge_raddr = e_minus[EADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_count_reg[EADDR_W-1:0]] <= '{next: adj_rd, target: to_reg,
                                                       cost: weight_reg};
        end
        edge_rd <= edge_mem[edge_raddr];
    end

    always_comb
    begin
        node_we    = 1'b0;
        node_waddr = init_cnt_reg;
        node_wdata = '{dist_val: DIST_MAX, queued: 1'b0, count: '0};
        if (cmd.init)
        begin
            node_we = 1'b1;
            if (init_cnt_reg == src_reg)
            begin
                node_wdata = '{dist_val: '0, queued: 1'b1, count: '0};
            end
        end
        else if (cmd.read_u)
        begin
            node_we    = 1'b1;
            node_waddr = u_reg;
            node_wdata = '{dist_val: node_rd.dist_val, queued: 1'b0, count: node_rd.count};
        end
        else if (cmd.relax && relax_hit && !status.abort)
        begin
            node_we    = 1'b1;
            node_waddr = v_reg;
            node_wdata = '{dist_val: nd_reg, queued: 1'b1,
                           count: node_rd.queued ? node_rd.count : new_count};
        end
    end

    assign node_raddr = cmd.pop_wait ? wq_rd : edge_rd.target;

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        node_rd <= node_mem[node_raddr];
    end

    assign wq_we    = cmd.accept_check || push;
    assign wq_waddr = cmd.accept_check ? '0 : tail_reg;
    assign wq_wdata = cmd.accept_check ? source_node : v_reg;

    always_ff @(posedge clk)
    begin
        if (wq_we)
        begin
            wq_mem[wq_waddr] <= wq_wdata;
        end
        wq_rd <= wq_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_add)
        begin
            from_reg   <= in_item.edge_from;
            to_reg     <= in_item.edge_to;
            weight_reg <= in_item.edge_weight;
        end
        if (cmd.accept_check)
        begin
            n_reg   <= n_live;
            src_reg <= source_node;
        end
        if (cmd.pop_wait)
        begin
            u_reg <= wq_rd;
        end
        if (cmd.read_u)
        begin
            du_reg <= node_rd.dist_val;
        end
        else if (cmd.relax && relax_hit && (v_reg == u_reg))
        begin
            du_reg <= nd_reg;
        end
        if (cmd.edge_wait)
        begin
            v_reg  <= edge_rd.target;
            nd_reg <= nd_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
            wipe_cnt_reg   <= '0;
            init_cnt_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            used_reg       <= '0;
            e_reg          <= '0;
            verdict_reg    <= 1'b1;
            out_valid_reg  <= 1'b0;
            out_item_reg   <= '0;
        end
        else
        begin
            if (cmd.accept_clear)
            begin
                edge_count_reg <= '0;
                overflow_reg   <= 1'b0;
            end
            else if (cmd.add_write)
            begin
                if (edge_full)
                begin
                    overflow_reg <= 1'b1;
                end
                else
                begin
                    edge_count_reg <= edge_count_reg + EIDX_W'(1);
                end
            end

            if (cmd.wipe)
            begin
                wipe_cnt_reg <= status.wipe_last ? '0 : wipe_cnt_reg + NODE_W'(1);
            end

            if (cmd.accept_check)
            begin
                init_cnt_reg <= '0;
                head_reg     <= '0;
                tail_reg     <= NODE_W'(1);
                used_reg     <= NCNT_W'(1);
                verdict_reg  <= 1'b1;
            end
            else
            begin
                if (cmd.init)
                begin
                    init_cnt_reg <= init_cnt_reg + NODE_W'(1);
                end
                if (cmd.pop)
                begin
                    head_reg <= head_reg + NODE_W'(1);
                    used_reg <= used_reg - NCNT_W'(1);
                end
                else if (push)
                begin
                    tail_reg <= tail_reg + NODE_W'(1);
                    used_reg <= used_reg + NCNT_W'(1);
                end
                if (cmd.relax && status.abort)
                begin
                    verdict_reg <= 1'b0;
                end
            end

            if (cmd.read_u)
            begin
                e_reg <= adj_rd;
            end
            else if (cmd.edge_wait)
            begin
                e_reg <= edge_rd.next;
            end

            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                out_item_reg  <= '{no_negative_cycle: verdict_reg,
                                   edges_dropped: overflow_reg};
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= NCNT_W'(MAX_NODES))
        else $error("work queue occupancy exceeds node capacity");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> (used_reg != '0))
        else $error("pop issued on an empty work queue");

    a_edges_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= EIDX_W'(MAX_EDGES))
        else $error("edge count exceeds edge store size");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(out_valid_reg && out_stall))
        else $error("result loaded over a pending transfer");

endmodule

[hw/rtl/negative_cycle_detector.sv]
// ---------------------------------------------------------------------------
// Negative cycle detector
// Edge store with queue-based Bellman-Ford check for reachable negative cycles.
// ---------------------------------------------------------------------------
// The input channel carries one item per transfer: an edge to add, a graph
// clear, or a cycle check. in_stall is high whenever the block is busy; it is
// low only in the idle state. An edge add occupies the block for the add
// state. A clear sweeps the adjacency heads of all 4096 nodes, one node per
// cycle. A check first initializes the state of each active node, then for
// each popped node reads its state and walks its outgoing edges, skipping an
// edge whose target is outside the active nodes. Each check produces exactly
// one result transfer on the output channel, held in an output register;
// when the receiver asserts out_stall the result waits there and the block
// keeps accepting adds and clears. Configuration registers node_count
// (address 0) and source_node (address 4) must be written over the APB-style
// port only while idle; the block itself does not enforce this. After reset
// the block runs the same clearing sweep before accepting its first item.
// ---------------------------------------------------------------------------
module negative_cycle_detector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ncd_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output ncd_pkg::out_item_t  out_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import ncd_pkg::*;

    logic [12:0] node_count_reg;
    logic [11:0] source_node_reg;
    logic        cfg_write;
    cmd_t        cmd;
    status_t     status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg  <= 13'd1;
            source_node_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                IDX_NODE_COUNT:  node_count_reg  <= pwdata[12:0];
                IDX_SOURCE_NODE: source_node_reg <= pwdata[11:0];
                default:         node_count_reg  <= node_count_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            IDX_NODE_COUNT:  prdata = 32'(node_count_reg);
            IDX_SOURCE_NODE: prdata = 32'(source_node_reg);
            default:         prdata = '0;
        endcase
    end

    ncd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_kind  (in_item.kind),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ncd_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_item     (in_item),
        .node_count  (node_count_reg),
        .source_node (source_node_reg),
        .out_stall   (out_stall),
        .status      (status),
        .out_valid   (out_valid),
        .out_item    (out_item)
    );

endmodule

[test/testbench.sv]
// ---------------------------------------------------------------------------
// Negative cycle detector testbench
// Loads random weighted graphs and runs cycle checks under several node count
// and source settings, with random gaps on both channels. Every check result
// is compared with a queue-based relaxation computed alongside the stimulus.
// Graph clears and unused item kinds are also covered.
// ---------------------------------------------------------------------------
module testbench;

    import ncd_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_NODE_COUNT = 3'(IDX_NODE_COUNT) << 2;
    localparam logic [2:0] ADDR_SOURCE_NODE = 3'(IDX_SOURCE_NODE) << 2;
    localparam longint DIST_TOP = (64'sd1 <<< (DIST_BITS - 1)) - 1;
    localparam longint DIST_BOTTOM = -DIST_TOP - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    negative_cycle_detector dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #5 clk = ~clk;

    in_item_t pending_items[$];
    out_item_t verdicts_due[$];
    bit calm = 1'b0;
    bit take_next;
    int mismatches = 0;

    logic [12:0] cfg_nodes = 13'd1;
    logic [11:0] cfg_source = 12'd0;
    int unsigned list_head[MAX_NODES];
    int unsigned edge_link[MAX_EDGES + 1];
    int unsigned edge_dest[MAX_EDGES + 1];
    longint edge_wt[MAX_EDGES + 1];
    int unsigned edges_held = 0;
    bit store_overflow = 1'b0;
    longint node_dist[MAX_NODES];
    bit queued[MAX_NODES];
    int unsigned times_queued[MAX_NODES];
    int unsigned relax_queue[MAX_NODES];

    function automatic bit cycle_free();
        int unsigned n, head, tail, used, u, e, v;
        longint nd;
        n = cfg_nodes;
        if (n < 1) n = 1;
        if (n > MAX_NODES) n = MAX_NODES;
        if (cfg_source >= n) return 1'b1;
        for (int i = 0; i < n; i++)
        begin
            node_dist[i] = DIST_TOP;
            queued[i] = 1'b0;
            times_queued[i] = 0;
        end
        node_dist[cfg_source] = 0;
        queued[cfg_source] = 1'b1;
        relax_queue[0] = cfg_source;
        head = 0;
        tail = 1;
        used = 1;
        while (used > 0)
        begin
            u = relax_queue[head];
            head = (head + 1) % MAX_NODES;
            used--;
            queued[u] = 1'b0;
            e = list_head[u];
            while (e != 0 && e <= MAX_EDGES)
            begin
                v = edge_dest[e];
                if (v < n)
                begin
                    nd = node_dist[u] + edge_wt[e];
                    if (nd > DIST_TOP) nd = DIST_TOP;
                    if (nd < DIST_BOTTOM) nd = DIST_BOTTOM;
                    if (node_dist[v] > nd)
                    begin
                        node_dist[v] = nd;
                        if (!queued[v])
                        begin
                            queued[v] = 1'b1;
                            times_queued[v]++;
                            if (times_queued[v] > n) return 1'b0;
                            relax_queue[tail] = v;
                            tail = (tail + 1) % MAX_NODES;
                            used++;
                        end
                    end
                end
                e = edge_link[e];
            end
        end
        return 1'b1;
    endfunction

    function automatic void apply_item(in_item_t it);
        out_item_t r;
        case (it.kind)
            KIND_ADD:
            begin
                if (edges_held >= MAX_EDGES)
                    store_overflow = 1'b1;
                else
                begin
                    edges_held++;
                    edge_link[edges_held] = list_head[it.edge_from];
                    edge_dest[edges_held] = it.edge_to;
                    edge_wt[edges_held] = longint'(it.edge_weight);
                    list_head[it.edge_from] = edges_held;
                end
            end
            KIND_CLEAR:
            begin
                foreach (list_head[i]) list_head[i] = 0;
                edges_held = 0;
                store_overflow = 1'b0;
            end
            KIND_CHECK:
            begin
                r.no_negative_cycle = cycle_free();
                r.edges_dropped = store_overflow;
                verdicts_due.push_back(r);
            end
            default: ;
        endcase
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            take_next = !in_valid || !in_stall;
            if (in_valid && !in_stall) apply_item(in_item);
            if (take_next)
            begin
                if (pending_items.size() > 0 && (calm || $urandom_range(99) >= 30))
                begin
                    in_valid <= 1'b1;
                    in_item <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (verdicts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: %b/%b",
                                 out_item.no_negative_cycle, out_item.edges_dropped);
                end
                else if (out_item.no_negative_cycle !== verdicts_due[0].no_negative_cycle ||
                         out_item.edges_dropped !== verdicts_due[0].edges_dropped)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %b/%b, got %b/%b",
                                 verdicts_due[0].no_negative_cycle,
                                 verdicts_due[0].edges_dropped,
                                 out_item.no_negative_cycle, out_item.edges_dropped);
                    void'(verdicts_due.pop_front());
                end
                else
                    void'(verdicts_due.pop_front());
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_NODE_COUNT)
            cfg_nodes = value[12:0];
        else
            cfg_source = value[11:0];
    endtask

    task automatic settle();
        do @(posedge clk);
        while (pending_items.size() != 0 || in_valid || verdicts_due.size() != 0);
        repeat (4200) @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic push_item(logic [1:0] kind, int unsigned from, int unsigned to,
                             logic [31:0] weight);
        in_item_t it;
        it.kind = kind;
        it.edge_from = from[11:0];
        it.edge_to = to[11:0];
        it.edge_weight = weight;
        pending_items.push_back(it);
    endtask

    function automatic logic [31:0] pick_weight();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8) return $urandom();
        if (sel < 11) return 32'h8000_0000;
        if (sel < 14) return 32'h7fff_ffff;
        return 32'($urandom_range(40)) - 32'd12;
    endfunction

    task automatic random_phase(int unsigned count, int unsigned span);
        int unsigned sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < 70)
            begin
                if ($urandom_range(9) == 0)
                    push_item(KIND_ADD, $urandom_range(4095), $urandom_range(4095),
                              pick_weight());
                else
                    push_item(KIND_ADD, $urandom_range(span + 1), $urandom_range(span + 1),
                              pick_weight());
            end
            else if (sel < 88)
                push_item(KIND_CHECK, $urandom(), $urandom(), $urandom());
            else if (sel < 93)
                push_item(KIND_CLEAR, $urandom(), $urandom(), $urandom());
            else
                push_item(KIND_UNUSED, $urandom(), $urandom(), $urandom());
        end
        push_item(KIND_CHECK, 0, 0, 0);
    endtask

    initial
    begin
        int unsigned span;
        foreach (list_head[i]) list_head[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);

        write_reg(ADDR_NODE_COUNT, 32'd4);
        write_reg(ADDR_SOURCE_NODE, 32'd0);
        push_item(KIND_CHECK, 0, 0, 0);
        push_item(KIND_ADD, 0, 1, 32'h7fff_ffff);
        push_item(KIND_ADD, 1, 2, 32'h8000_0000);
        push_item(KIND_ADD, 2, 3, 32'h0000_0000);
        push_item(KIND_ADD, 0, 4095, 32'hffff_ffff);
        push_item(KIND_ADD, 4095, 4095, 32'h8000_0000);
        push_item(KIND_UNUSED, 4095, 4095, 32'hffff_ffff);
        push_item(KIND_CHECK, 4095, 4095, 32'hffff_ffff);
        push_item(KIND_ADD, 3, 0, 32'h7fff_ffff);
        push_item(KIND_CHECK, 0, 0, 0);
        push_item(KIND_ADD, 3, 3, 32'hffff_ffff);
        push_item(KIND_CHECK, 0, 0, 0);
        push_item(KIND_CLEAR, 0, 0, 0);
        push_item(KIND_ADD, 1, 1, 32'hffff_fffe);
        push_item(KIND_CHECK, 0, 0, 0);
        push_item(KIND_ADD, 0, 1, 32'd5);
        push_item(KIND_CHECK, 0, 0, 0);
        settle();

        write_reg(ADDR_SOURCE_NODE, 32'd4095);
        push_item(KIND_CHECK, 0, 0, 0);
        settle();
        write_reg(ADDR_NODE_COUNT, 32'd0);
        write_reg(ADDR_SOURCE_NODE, 32'd0);
        push_item(KIND_CHECK, 0, 0, 0);
        settle();
        write_reg(ADDR_NODE_COUNT, 32'h1fff);
        push_item(KIND_ADD, 0, 2, 32'd3);
        push_item(KIND_ADD, 2, 0, 32'hffff_fffc);
        push_item(KIND_CHECK, 0, 0, 0);
        settle();
        write_reg(ADDR_NODE_COUNT, 32'd4096);
        write_reg(ADDR_SOURCE_NODE, 32'd4095);
        push_item(KIND_CLEAR, 0, 0, 0);
        push_item(KIND_ADD, 4095, 7, 32'hffff_fff0);
        push_item(KIND_CHECK, 0, 0, 0);
        settle();

        write_reg(ADDR_NODE_COUNT, 32'd3);
        write_reg(ADDR_SOURCE_NODE, 32'd0);
        calm = 1'b1;
        push_item(KIND_ADD, 0, 1, 32'hffff_ffff);
        push_item(KIND_ADD, 1, 0, 32'hffff_ffff);
        push_item(KIND_CHECK, 0, 0, 0);
        push_item(KIND_CLEAR, 0, 0, 0);
        push_item(KIND_CHECK, 0, 0, 0);
        settle();
        calm = 1'b0;

        for (int p = 0; p < 20; p++)
        begin
            span = $urandom_range(1, 12);
            write_reg(ADDR_NODE_COUNT, span);
            write_reg(ADDR_SOURCE_NODE, ($urandom_range(9) == 0) ? span + 1
                                                                  : $urandom_range(span - 1));
            calm = (p == 7);
            random_phase(26, span);
            settle();
        end

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #200000000;
        $display("status: fail");
        $finish;
    end

endmodule
